/* hw/rtl/ozsl_pkg.sv */
// obstacle zone speed limiter: shared types, register codes and zone codes
// no dependencies; imported by every module of the block
package ozsl_pkg;

    // sample counter width and saturation
    localparam int INDEX_BITS = 12;
    localparam int SCAN_W     = 12;
    // compare width for sector bounds against the sample counter
    localparam int CMP_W      = (INDEX_BITS > SCAN_W) ? INDEX_BITS : SCAN_W;

    localparam int RANGE_W    = 16;
    localparam int SPEED_W    = 16;
    localparam int GAIN_W     = 9;
    localparam int ZONE_W     = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // value held by a sector with no valid reading
    localparam logic [RANGE_W-1:0] NO_READING = RANGE_W'(50000);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SCAN_POINTS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NEAR_MM     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MID_MM      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FAR_MM      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GENTLE_GAIN = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_STRONG_GAIN = 3'd5;

    // configuration reset values
    localparam logic [SCAN_W-1:0]  RST_SCAN_POINTS = 12'd720;
    localparam logic [RANGE_W-1:0] RST_NEAR_MM     = 16'd1000;
    localparam logic [RANGE_W-1:0] RST_MID_MM      = 16'd1500;
    localparam logic [RANGE_W-1:0] RST_FAR_MM      = 16'd2000;
    localparam logic [GAIN_W-1:0]  RST_GENTLE_GAIN = 9'd205;
    localparam logic [GAIN_W-1:0]  RST_STRONG_GAIN = 9'd128;

    // zone flag codes
    localparam logic [ZONE_W-1:0] ZONE_CLEAR  = 3'd0;
    localparam logic [ZONE_W-1:0] ZONE_R_FAR  = 3'd1;
    localparam logic [ZONE_W-1:0] ZONE_R_MID  = 3'd2;
    localparam logic [ZONE_W-1:0] ZONE_R_NEAR = 3'd3;
    localparam logic [ZONE_W-1:0] ZONE_L_FAR  = 3'd4;
    localparam logic [ZONE_W-1:0] ZONE_L_MID  = 3'd5;
    localparam logic [ZONE_W-1:0] ZONE_L_NEAR = 3'd6;

    // input mode codes
    localparam logic MODE_SAMPLE  = 1'b0;
    localparam logic MODE_COMMAND = 1'b1;

    // configuration register file contents
    typedef struct packed {
        logic [SCAN_W-1:0]  scan_points;
        logic [RANGE_W-1:0] near_mm;
        logic [RANGE_W-1:0] mid_mm;
        logic [RANGE_W-1:0] far_mm;
        logic [GAIN_W-1:0]  gentle_gain;
        logic [GAIN_W-1:0]  strong_gain;
    } cfg_t;

endpackage

/* hw/rtl/obstacle_zone_speed_limiter.sv */
// obstacle zone speed limiter top level: config registers, input and result registers
// depends on ozsl_pkg, ozsl_scan and ozsl_limit

// Range samples (mode 0) and velocity commands (mode 1) share one valid/ready
// input channel. Each item is processed in an input register, and a command's
// result is then held in an output register until taken; one item is accepted
// per cycle while the output side keeps up, and a sample never waits on the
// output side. A sample produces no result; each command produces one result
// with the limited speeds and the zone flag in force. A command reaches
// out_valid through the input register and then the result register.
// A sample marked scan_end sets the zone used by every command accepted after
// it. Configuration writes take effect at once and belong to idle periods.
module obstacle_zone_speed_limiter (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // configuration write port
    input  logic                                 cfg_we,
    input  logic [ozsl_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [ozsl_pkg::CFG_DATA_W-1:0]      cfg_data,
    // input channel
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic                                 mode,
    input  logic [ozsl_pkg::RANGE_W-1:0]         range_mm,
    input  logic                                 scan_end,
    input  logic signed [ozsl_pkg::SPEED_W-1:0]  linear_x,
    input  logic signed [ozsl_pkg::SPEED_W-1:0]  angular_z,
    // result channel
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [ozsl_pkg::SPEED_W-1:0]  linear_out,
    output logic signed [ozsl_pkg::SPEED_W-1:0]  angular_out,
    output logic [ozsl_pkg::ZONE_W-1:0]          zone_flag
);
    import ozsl_pkg::*;

    cfg_t                  cfg_reg;

    logic                  in_valid_reg;
    logic                  mode_reg;
    logic [RANGE_W-1:0]    range_reg;
    logic                  scan_end_reg;
    logic signed [SPEED_W-1:0] lin_reg, ang_reg;

    logic                  out_valid_reg;
    logic signed [SPEED_W-1:0] lin_out_reg, ang_out_reg;
    logic [ZONE_W-1:0]     zone_out_reg;

    logic                  advance, in_fire, sample_fire, cmd_fire;
    logic [ZONE_W-1:0]     zone;
    logic signed [SPEED_W-1:0] lin_lim, ang_lim;

    // configuration register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.scan_points <= RST_SCAN_POINTS;
            cfg_reg.near_mm     <= RST_NEAR_MM;
            cfg_reg.mid_mm      <= RST_MID_MM;
            cfg_reg.far_mm      <= RST_FAR_MM;
            cfg_reg.gentle_gain <= RST_GENTLE_GAIN;
            cfg_reg.strong_gain <= RST_STRONG_GAIN;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SCAN_POINTS: cfg_reg.scan_points <= cfg_data[SCAN_W-1:0];
                CFG_NEAR_MM:     cfg_reg.near_mm     <= cfg_data[RANGE_W-1:0];
                CFG_MID_MM:      cfg_reg.mid_mm      <= cfg_data[RANGE_W-1:0];
                CFG_FAR_MM:      cfg_reg.far_mm      <= cfg_data[RANGE_W-1:0];
                CFG_GENTLE_GAIN: cfg_reg.gentle_gain <= cfg_data[GAIN_W-1:0];
                CFG_STRONG_GAIN: cfg_reg.strong_gain <= cfg_data[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    // handshake: the input stage drains when a sample or a command has room
    always_comb
    begin
        advance     = in_valid_reg &&
                      ((mode_reg == MODE_SAMPLE) || !out_valid_reg || out_ready);
        sample_fire = advance && (mode_reg == MODE_SAMPLE);
        cmd_fire    = advance && (mode_reg == MODE_COMMAND);
        in_ready    = !in_valid_reg || advance;
        in_fire     = in_valid && in_ready;
    end

    // input register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_ready)
            in_valid_reg <= in_valid;
    end

    // input register payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            mode_reg     <= mode;
            range_reg    <= range_mm;
            scan_end_reg <= scan_end;
            lin_reg      <= linear_x;
            ang_reg      <= angular_z;
        end
    end

    ozsl_scan u_scan (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .sample_fire (sample_fire),
        .range_mm    (range_reg),
        .scan_end    (scan_end_reg),
        .zone        (zone)
    );

    ozsl_limit u_limit (
        .cfg         (cfg_reg),
        .zone        (zone),
        .linear_x    (lin_reg),
        .angular_z   (ang_reg),
        .linear_out  (lin_lim),
        .angular_out (ang_lim)
    );

    // result register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd_fire)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    // result register payload
    always_ff @(posedge clk)
    begin
        if (cmd_fire)
        begin
            lin_out_reg  <= lin_lim;
            ang_out_reg  <= ang_lim;
            zone_out_reg <= zone;
        end
    end

    assign out_valid   = out_valid_reg;
    assign linear_out  = lin_out_reg;
    assign angular_out = ang_out_reg;
    assign zone_flag   = zone_out_reg;

    // a sample never creates a result
    a_sample_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && mode_reg == MODE_SAMPLE && !out_valid_reg) |=> !out_valid_reg)
        else $error("result produced by a range sample");

    // an empty input stage always takes a transfer
    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> in_ready)
        else $error("input stalled while empty");

    // a pending sample never stalls the input
    a_sample_flows: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && mode_reg == MODE_SAMPLE) |-> in_ready)
        else $error("range sample stalled by output side");

    // a result held but not taken is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |-> !cmd_fire)
        else $error("pending result overwritten");

endmodule

/* hw/rtl/ozsl_scan.sv */
// obstacle zone speed limiter: per-scan sector tracking and zone decision
// depends on ozsl_pkg
module ozsl_scan (
    input  logic                          clk,
    input  logic                          rst_n,
    input  ozsl_pkg::cfg_t                cfg,
    input  logic                          sample_fire,
    input  logic [ozsl_pkg::RANGE_W-1:0]  range_mm,
    input  logic                          scan_end,
    output logic [ozsl_pkg::ZONE_W-1:0]   zone
);
    import ozsl_pkg::*;

    logic [INDEX_BITS-1:0] idx_reg, idx_next;
    logic [RANGE_W-1:0]    right_reg, right_next;
    logic [RANGE_W-1:0]    left_reg, left_next;
    logic                  right_valid_reg, right_valid_next;
    logic                  left_valid_reg, left_valid_next;
    logic [ZONE_W-1:0]     zone_reg, zone_next;

    logic [SCAN_W+2:0]     lo_wide, hi_wide;
    logic [CMP_W-1:0]      lo_bound, mid_bound, hi_bound, idx_ext;
    logic                  in_range, right_upd, left_upd;
    logic [RANGE_W-1:0]    right_new, left_new;
    logic                  right_new_valid, left_new_valid;
    logic                  right_wins, left_wins;
    logic [ZONE_W-1:0]     zone_close;

    // sector bounds: 3N/8, N/2, 5N/8 with integer division
    always_comb
    begin
        lo_wide   = ({3'b000, cfg.scan_points} + {2'b00, cfg.scan_points, 1'b0}) >> 3;
        hi_wide   = ({3'b000, cfg.scan_points} + {1'b0, cfg.scan_points, 2'b00}) >> 3;
        lo_bound  = CMP_W'(lo_wide);
        hi_bound  = CMP_W'(hi_wide);
        mid_bound = CMP_W'(cfg.scan_points >> 1);
        idx_ext   = CMP_W'(idx_reg);
    end

    // nearest reading update for both sectors
    always_comb
    begin
        in_range  = (range_mm != '0) && (range_mm < cfg.far_mm);
        right_upd = in_range && (idx_ext >= lo_bound) && (idx_ext <= mid_bound) &&
                    (!right_valid_reg || (range_mm < right_reg));
        left_upd  = in_range && (idx_ext >= mid_bound) && (idx_ext <= hi_bound) &&
                    (!left_valid_reg || (range_mm < left_reg));
        right_new       = right_upd ? range_mm : right_reg;
        left_new        = left_upd ? range_mm : left_reg;
        right_new_valid = right_valid_reg || right_upd;
        left_new_valid  = left_valid_reg || left_upd;
    end

    // zone decision at the end of a scan
    always_comb
    begin
        right_wins = right_new_valid && (!left_new_valid || (right_new < left_new));
        left_wins  = left_new_valid && (!right_new_valid || (left_new < right_new));
        if (right_wins)
        begin
            if (right_new < cfg.near_mm)
                zone_close = ZONE_R_NEAR;
            else if (right_new < cfg.mid_mm)
                zone_close = ZONE_R_MID;
            else
                zone_close = ZONE_R_FAR;
        end
        else if (left_wins)
        begin
            if (left_new < cfg.near_mm)
                zone_close = ZONE_L_NEAR;
            else if (left_new < cfg.mid_mm)
                zone_close = ZONE_L_MID;
            else
                zone_close = ZONE_L_FAR;
        end
        else
        begin
            zone_close = ZONE_CLEAR;
        end
    end

    // next state
    always_comb
    begin
        idx_next         = idx_reg;
        right_next       = right_reg;
        left_next        = left_reg;
        right_valid_next = right_valid_reg;
        left_valid_next  = left_valid_reg;
        zone_next        = zone_reg;
        if (sample_fire)
        begin
            if (scan_end)
            begin
                idx_next         = '0;
                right_next       = NO_READING;
                left_next        = NO_READING;
                right_valid_next = 1'b0;
                left_valid_next  = 1'b0;
                zone_next        = zone_close;
            end
            else
            begin
                idx_next         = (&idx_reg) ? idx_reg : idx_reg + 1'b1;
                right_next       = right_new;
                left_next        = left_new;
                right_valid_next = right_new_valid;
                left_valid_next  = left_new_valid;
            end
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg         <= '0;
            right_reg       <= NO_READING;
            left_reg        <= NO_READING;
            right_valid_reg <= 1'b0;
            left_valid_reg  <= 1'b0;
            zone_reg        <= ZONE_CLEAR;
        end
        else
        begin
            idx_reg         <= idx_next;
            right_reg       <= right_next;
            left_reg        <= left_next;
            right_valid_reg <= right_valid_next;
            left_valid_reg  <= left_valid_next;
            zone_reg        <= zone_next;
        end
    end

    assign zone = zone_reg;

    // a held reading is never zero
    a_right_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        right_valid_reg |-> (right_reg != '0))
        else $error("right sector holds a zero reading");

    a_left_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        left_valid_reg |-> (left_reg != '0))
        else $error("left sector holds a zero reading");

    // the end of a scan restarts the sector tracking
    a_scan_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (sample_fire && scan_end) |=> (idx_reg == '0 && !right_valid_reg && !left_valid_reg))
        else $error("scan state not cleared at scan end");

    // a sector with no reading holds the sentinel
    a_sentinel: assert property (@(posedge clk) disable iff (!rst_n)
        !right_valid_reg |-> (right_reg == NO_READING))
        else $error("empty right sector lost its sentinel");

endmodule

/* hw/rtl/ozsl_limit.sv */
// obstacle zone speed limiter: velocity command scaling against the zone
// depends on ozsl_pkg
module ozsl_limit (
    input  ozsl_pkg::cfg_t                       cfg,
    input  logic [ozsl_pkg::ZONE_W-1:0]          zone,
    input  logic signed [ozsl_pkg::SPEED_W-1:0]  linear_x,
    input  logic signed [ozsl_pkg::SPEED_W-1:0]  angular_z,
    output logic signed [ozsl_pkg::SPEED_W-1:0]  linear_out,
    output logic signed [ozsl_pkg::SPEED_W-1:0]  angular_out
);
    import ozsl_pkg::*;

    localparam int PROD_W = SPEED_W + GAIN_W + 1;
    localparam int QUOT_W = PROD_W - 8;
    localparam logic signed [QUOT_W-1:0] SAT_HI = QUOT_W'(32767);
    localparam logic signed [QUOT_W-1:0] SAT_LO = -QUOT_W'(32768);

    logic                      toward_right, toward_left, hit_right, hit_left;
    logic [GAIN_W-1:0]         gain;
    logic signed [GAIN_W:0]    gain_s;
    logic signed [PROD_W-1:0]  lin_prod, ang_prod;
    logic signed [QUOT_W-1:0]  lin_q, ang_q;
    logic signed [SPEED_W-1:0] lin_sat, ang_sat;

    // direction of the command relative to the flagged side
    always_comb
    begin
        toward_right = (linear_x > 0) || (angular_z < 0);
        toward_left  = (linear_x > 0) || (angular_z > 0);
        hit_right    = (zone == ZONE_R_FAR || zone == ZONE_R_MID || zone == ZONE_R_NEAR)
                       && toward_right;
        hit_left     = (zone == ZONE_L_FAR || zone == ZONE_L_MID || zone == ZONE_L_NEAR)
                       && toward_left;
    end

    // q8 scaling with floor and saturation
    always_comb
    begin
        gain     = (zone == ZONE_R_FAR || zone == ZONE_L_FAR) ? cfg.gentle_gain
                                                              : cfg.strong_gain;
        gain_s   = $signed({1'b0, gain});
        lin_prod = PROD_W'(linear_x) * PROD_W'(gain_s);
        ang_prod = PROD_W'(angular_z) * PROD_W'(gain_s);
        lin_q    = QUOT_W'(lin_prod >>> 8);
        ang_q    = QUOT_W'(ang_prod >>> 8);
        if (lin_q > SAT_HI)
            lin_sat = 16'sh7fff;
        else if (lin_q < SAT_LO)
            lin_sat = 16'sh8000;
        else
            lin_sat = SPEED_W'(lin_q);
        if (ang_q > SAT_HI)
            ang_sat = 16'sh7fff;
        else if (ang_q < SAT_LO)
            ang_sat = 16'sh8000;
        else
            ang_sat = SPEED_W'(ang_q);
    end

    // band selection for a command heading toward the flagged side: stop in the near band, scale otherwise
    always_comb
    begin
        linear_out  = linear_x;
        angular_out = angular_z;
        if (hit_right || hit_left)
        begin
            if (zone == ZONE_R_NEAR || zone == ZONE_L_NEAR)
            begin
                linear_out  = '0;
                angular_out = '0;
            end
            else
            begin
                linear_out  = lin_sat;
                angular_out = ang_sat;
            end
        end
    end

endmodule

/* dv/obstacle_zone_speed_limiter_tb.sv */
// testbench for obstacle_zone_speed_limiter: scans and velocity commands in, limited commands out
// needs ozsl_pkg and the rtl top; predicts zones and limited speeds, checks every result transfer
module obstacle_zone_speed_limiter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ozsl_pkg::*;

    // register indexes the block has no register for
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_7 = 3'd7;

    typedef struct {
        logic signed [SPEED_W-1:0] lin;
        logic signed [SPEED_W-1:0] ang;
        logic [ZONE_W-1:0]         zone;
    } limited_cmd_t;

    // tracks sector minimums and zone, queues the limited command each command should produce
    class speed_limiter_checker;
        cfg_t                  cfg;
        logic [INDEX_BITS-1:0] sample_idx;
        logic [RANGE_W-1:0]    right_min;
        logic [RANGE_W-1:0]    left_min;
        bit                    right_seen;
        bit                    left_seen;
        logic [ZONE_W-1:0]     zone;
        limited_cmd_t          pending_cmds[$];
        int                    errors;
        int                    samples;
        int                    commands;
        int                    scans;
        bit [6:0]              zones_hit;

        function new();
            cfg.scan_points = RST_SCAN_POINTS;
            cfg.near_mm     = RST_NEAR_MM;
            cfg.mid_mm      = RST_MID_MM;
            cfg.far_mm      = RST_FAR_MM;
            cfg.gentle_gain = RST_GENTLE_GAIN;
            cfg.strong_gain = RST_STRONG_GAIN;
            zone      = ZONE_CLEAR;
            errors    = 0;
            samples   = 0;
            commands  = 0;
            scans     = 0;
            zones_hit = '0;
            restart_scan();
        endfunction

        function void restart_scan();
            sample_idx = '0;
            right_min  = NO_READING;
            left_min   = NO_READING;
            right_seen = 1'b0;
            left_seen  = 1'b0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_SCAN_POINTS: cfg.scan_points = data[SCAN_W-1:0];
                CFG_NEAR_MM:     cfg.near_mm     = data;
                CFG_MID_MM:      cfg.mid_mm      = data;
                CFG_FAR_MM:      cfg.far_mm      = data;
                CFG_GENTLE_GAIN: cfg.gentle_gain = data[GAIN_W-1:0];
                CFG_STRONG_GAIN: cfg.strong_gain = data[GAIN_W-1:0];
                default: ;
            endcase
        endfunction

        // near test first, then mid, else far band
        function logic [ZONE_W-1:0] band_of(logic [RANGE_W-1:0] d, bit left);
            if (d < cfg.near_mm)
                return left ? ZONE_L_NEAR : ZONE_R_NEAR;
            if (d < cfg.mid_mm)
                return left ? ZONE_L_MID : ZONE_R_MID;
            return left ? ZONE_L_FAR : ZONE_R_FAR;
        endfunction

        function void close_scan();
            if (right_seen && (!left_seen || right_min < left_min))
                zone = band_of(right_min, 1'b0);
            else if (left_seen && (!right_seen || left_min < right_min))
                zone = band_of(left_min, 1'b1);
            else
                zone = ZONE_CLEAR;
            scans++;
            zones_hit[zone] = 1'b1;
            restart_scan();
        endfunction

        function void take_sample(logic [RANGE_W-1:0] r, logic last);
            int n;
            int lo;
            int md;
            int hi;
            int i;
            n  = cfg.scan_points;
            lo = n * 3 / 8;
            md = n / 2;
            hi = n * 5 / 8;
            i  = sample_idx;
            samples++;
            // sector bounds inclusive, the middle index counts for both sides
            if (r != '0 && r < cfg.far_mm)
            begin
                if (i >= lo && i <= md && (!right_seen || r < right_min))
                begin
                    right_min  = r;
                    right_seen = 1'b1;
                end
                if (i >= md && i <= hi && (!left_seen || r < left_min))
                begin
                    left_min  = r;
                    left_seen = 1'b1;
                end
            end
            if (sample_idx != {INDEX_BITS{1'b1}})
                sample_idx = sample_idx + 1'b1;
            if (last)
                close_scan();
        endfunction

        // q8 gain, floored product, clamped to the signed speed range
        function logic signed [SPEED_W-1:0] scale_by_gain(logic signed [SPEED_W-1:0] v,
                                                          logic [GAIN_W-1:0] g);
            int p;
            int q;
            p = int'(v) * int'({1'b0, g});
            q = p >>> 8;
            if (q > 32767)
                q = 32767;
            else if (q < -32768)
                q = -32768;
            return SPEED_W'(q);
        endfunction

        function void take_command(logic signed [SPEED_W-1:0] lin,
                                   logic signed [SPEED_W-1:0] ang);
            limited_cmd_t e;
            bit heads_right;
            bit heads_left;
            bit hit;
            e.lin  = lin;
            e.ang  = ang;
            e.zone = zone;
            heads_right = (lin > 0) || (ang < 0);
            heads_left  = (lin > 0) || (ang > 0);
            case (zone)
                ZONE_R_FAR, ZONE_R_MID, ZONE_R_NEAR: hit = heads_right;
                ZONE_L_FAR, ZONE_L_MID, ZONE_L_NEAR: hit = heads_left;
                default: hit = 1'b0;
            endcase
            if (hit)
            begin
                case (zone)
                    ZONE_R_NEAR, ZONE_L_NEAR:
                    begin
                        e.lin = '0;
                        e.ang = '0;
                    end
                    ZONE_R_MID, ZONE_L_MID:
                    begin
                        e.lin = scale_by_gain(lin, cfg.strong_gain);
                        e.ang = scale_by_gain(ang, cfg.strong_gain);
                    end
                    default:
                    begin
                        e.lin = scale_by_gain(lin, cfg.gentle_gain);
                        e.ang = scale_by_gain(ang, cfg.gentle_gain);
                    end
                endcase
            end
            commands++;
            pending_cmds.push_back(e);
        endfunction

        // accepted input transfer
        function void observe_item(logic m, logic [RANGE_W-1:0] r, logic last,
                                   logic signed [SPEED_W-1:0] lx, logic signed [SPEED_W-1:0] az);
            if (m == MODE_COMMAND)
                take_command(lx, az);
            else
                take_sample(r, last);
        endfunction

        // accepted result transfer against the oldest queued command
        function void compare_result(logic signed [SPEED_W-1:0] lin,
                                     logic signed [SPEED_W-1:0] ang,
                                     logic [ZONE_W-1:0] zf);
            limited_cmd_t e;
            if (pending_cmds.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: linear %0d angular %0d zone %0d", lin, ang, zf);
                return;
            end
            e = pending_cmds.pop_front();
            if (lin !== e.lin || ang !== e.ang || zf !== e.zone)
            begin
                errors++;
                if (errors <= 10)
                    $display({"mismatch: linear exp %0d got %0d, angular exp %0d got %0d,",
                              " zone exp %0d got %0d"},
                             e.lin, lin, e.ang, ang, e.zone, zf);
            end
        endfunction

        function void flag_leftovers();
            if (pending_cmds.size() != 0)
            begin
                $display("%0d commands never produced a result", pending_cmds.size());
                errors += pending_cmds.size();
            end
        endfunction
    endclass

    logic                        clk;
    logic                        rst_n;
    logic                        cfg_we;
    logic [CFG_IDX_W-1:0]        cfg_index;
    logic [CFG_DATA_W-1:0]       cfg_data;
    logic                        in_valid;
    logic                        in_ready;
    logic                        mode;
    logic [RANGE_W-1:0]          range_mm;
    logic                        scan_end;
    logic signed [SPEED_W-1:0]   linear_x;
    logic signed [SPEED_W-1:0]   angular_z;
    logic                        out_valid;
    logic                        out_ready;
    logic signed [SPEED_W-1:0]   linear_out;
    logic signed [SPEED_W-1:0]   angular_out;
    logic [ZONE_W-1:0]           zone_flag;

    speed_limiter_checker sb = new();
    bit no_idle      = 1'b0;
    int hold_request = 0;
    int items_sent   = 0;

    obstacle_zone_speed_limiter u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .mode        (mode),
        .range_mm    (range_mm),
        .scan_end    (scan_end),
        .linear_x    (linear_x),
        .angular_z   (angular_z),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .linear_out  (linear_out),
        .angular_out (angular_out),
        .zone_flag   (zone_flag)
    );

    // 2 ns clock
    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // sender gap: mostly none or short, a few long
    function automatic int idle_gap();
        int sel;
        sel = $urandom_range(99);
        if (no_idle || sel < 60)
            return 0;
        if (sel < 90)
            return $urandom_range(3, 1);
        if (sel < 98)
            return $urandom_range(10, 4);
        return $urandom_range(40, 20);
    endfunction

    // readings spread over the bands, the far edge, zero and anything at all
    function automatic logic [RANGE_W-1:0] pick_range();
        int far;
        far = sb.cfg.far_mm;
        case ($urandom_range(9))
            0: return '0;
            1: return RANGE_W'($urandom);
            2: return RANGE_W'(far);
            3: return (far == 0) ? RANGE_W'(0) : RANGE_W'(far - 1);
            default: return (far <= 1) ? RANGE_W'($urandom) : RANGE_W'($urandom_range(far - 1, 1));
        endcase
    endfunction

    function automatic logic signed [SPEED_W-1:0] pick_speed();
        case ($urandom_range(7))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return '0;
            3: return SPEED_W'(int'($urandom_range(400)) - 200);
            default: return SPEED_W'($urandom);
        endcase
    endfunction

    // one input transfer, then an optional gap with valid low
    task automatic send_item(logic m, logic [RANGE_W-1:0] r, logic last,
                             logic signed [SPEED_W-1:0] lx, logic signed [SPEED_W-1:0] az, int gap);
        in_valid  <= 1'b1;
        mode      <= m;
        range_mm  <= r;
        scan_end  <= last;
        linear_x  <= lx;
        angular_z <= az;
        do
            @(posedge clk);
        while (!in_ready);
        items_sent++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_sample(logic [RANGE_W-1:0] r, logic last);
        send_item(MODE_SAMPLE, r, last, SPEED_W'($urandom), SPEED_W'($urandom), idle_gap());
    endtask

    task automatic send_command(logic signed [SPEED_W-1:0] lx, logic signed [SPEED_W-1:0] az);
        send_item(MODE_COMMAND, RANGE_W'($urandom), 1'($urandom_range(1)), lx, az, idle_gap());
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        sb.set_register(idx, data);
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apply_settings(logic [CFG_DATA_W-1:0] n, logic [CFG_DATA_W-1:0] near,
                                  logic [CFG_DATA_W-1:0] mid, logic [CFG_DATA_W-1:0] far,
                                  logic [CFG_DATA_W-1:0] gentle_g,
                                  logic [CFG_DATA_W-1:0] strong_g);
        write_reg(CFG_SCAN_POINTS, n);
        write_reg(CFG_NEAR_MM, near);
        write_reg(CFG_MID_MM, mid);
        write_reg(CFG_FAR_MM, far);
        write_reg(CFG_GENTLE_GAIN, gentle_g);
        write_reg(CFG_STRONG_GAIN, strong_g);
    endtask

    // drop valid, wait for outstanding results, then let a trailing sample finish
    task automatic settle();
        int waited;
        waited = 0;
        in_valid <= 1'b0;
        while (sb.pending_cmds.size() != 0 && waited < 20000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (4) @(posedge clk);
    endtask

    // one scan with random content: mostly full length, some short, some overlong
    task automatic random_scan();
        int n;
        int len;
        int sel;
        int k;
        n   = (sb.cfg.scan_points == 0) ? 1 : sb.cfg.scan_points;
        sel = $urandom_range(19);
        if (sel < 3)
            len = $urandom_range(n, 1);
        else if (sel == 3)
            len = n + $urandom_range(6, 1);
        else
            len = n;
        no_idle = ($urandom_range(4) == 0);
        for (k = 0; k < len; k++)
        begin
            if ($urandom_range(9) == 0)
                send_command(pick_speed(), pick_speed());
            send_sample(pick_range(), k == len - 1);
        end
        repeat ($urandom_range(3, 1)) send_command(pick_speed(), pick_speed());
        no_idle = 1'b0;
    endtask

    task automatic random_phase(int count);
        int start;
        start = items_sent;
        while (items_sent - start < count)
            random_scan();
        settle();
    endtask

    // stimulus
    initial
    begin
        logic [RANGE_W-1:0] first_scan [8] = '{16'd65535, 16'd0, 16'd1999, 16'd1200,
                                               16'd1800, 16'd900, 16'd2000, 16'd1};
        logic [RANGE_W-1:0] equal_scan [5] = '{16'd0, 16'd0, 16'd0, 16'd1700, 16'd1700};
        int i;

        in_valid  <= 1'b0;
        mode      <= MODE_SAMPLE;
        range_mm  <= '0;
        scan_end  <= 1'b0;
        linear_x  <= '0;
        angular_z <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= CFG_SCAN_POINTS;
        cfg_data  <= '0;
        rst_n     <= 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: a one-sample scan with nothing valid, commands pass through
        send_sample(16'd0, 1'b1);
        send_command(16'sh7fff, 16'sh8000);
        send_command(16'sh8000, 16'sh7fff);
        send_command(16'sd0, 16'sd0);
        settle();

        // eight-point scans: left near zone, then equal sides in a short scan
        apply_settings(16'd8, 16'd1000, 16'd1500, 16'd2000, 16'd205, 16'd128);
        for (i = 0; i < 8; i++)
            send_sample(first_scan[i], i == 7);
        send_command(16'sd100, -16'sd5);
        send_command(-16'sd100, -16'sd300);
        for (i = 0; i < 5; i++)
            send_sample(equal_scan[i], i == 4);
        send_command(16'sh7fff, 16'sh7fff);
        settle();

        // random traffic under several settings; receiver holds off early on
        hold_request = 150;
        random_phase(100);

        // single-point scans: both sectors are index 0, gain writes truncated to 9 bits
        apply_settings(16'd1, 16'd300, 16'd200, 16'd400, 16'hFFFF, 16'd256);
        random_phase(40);

        // odd count, every reading in the far band, gain above unity saturates
        apply_settings(16'd13, 16'd0, 16'd0, 16'd65535, 16'hFFFF, 16'd300);
        random_phase(100);

        // truncated point count (11), everything near; spare indexes ignored
        apply_settings(16'hF00B, 16'd65535, 16'd65535, 16'd65535, 16'd0, 16'd0);
        write_reg(CFG_SPARE_6, 16'd3);
        write_reg(CFG_SPARE_7, 16'hFFFF);
        random_phase(100);

        // far below mid, unity and zero gains
        apply_settings(16'd20, 16'd800, 16'd1800, 16'd1500, 16'd256, 16'd0);
        random_phase(100);

        // far of zero: no reading is ever valid
        apply_settings(16'd2, 16'd500, 16'd900, 16'd0, 16'd100, 16'd50);
        random_phase(40);

        // random thresholds and gains
        apply_settings(16'd6, 16'($urandom_range(2500)), 16'($urandom_range(2500)),
                       16'($urandom_range(2500, 200)), 16'($urandom_range(300)),
                       16'($urandom_range(300)));
        random_phase(100);

        repeat (10) @(posedge clk);
        sb.flag_leftovers();
        $display("covered %0d samples in %0d closed scans and %0d commands across eight settings",
                 sb.samples, sb.scans, sb.commands);
        $display("zone codes reached (bit per code): %b, failures: %0d", sb.zones_hit, sb.errors);
        if (sb.errors == 0)
            $display("obstacle_zone_speed_limiter_tb: done, clean");
        else
            $display("obstacle_zone_speed_limiter_tb: done, errors");
        $finish;
    end

    // receiver: ready runs and stalls of random length, plus one long hold-off on request
    initial
    begin
        int run;
        int stall;
        int held;
        out_ready <= 1'b0;
        do
            @(posedge clk);
        while (!rst_n);
        forever
        begin
            if (hold_request > 0)
            begin
                held = hold_request;
                hold_request = 0;
                out_ready <= 1'b0;
                repeat (held) @(posedge clk);
            end
            else
            begin
                case ($urandom_range(9))
                    0: run = $urandom_range(150, 60);
                    1, 2: run = $urandom_range(40, 10);
                    default: run = $urandom_range(8, 1);
                endcase
                out_ready <= 1'b1;
                repeat (run) @(posedge clk);
                stall = $urandom_range(99);
                if (stall < 40)
                    stall = 0;
                else if (stall < 88)
                    stall = $urandom_range(3, 1);
                else if (stall < 97)
                    stall = $urandom_range(10, 4);
                else
                    stall = $urandom_range(40, 20);
                if (stall > 0)
                begin
                    out_ready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
            end
        end
    end

    // monitor: input transfers feed the prediction, result transfers are checked
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n)
            begin
                if (in_valid && in_ready)
                    sb.observe_item(mode, range_mm, scan_end, linear_x, angular_z);
                if (out_valid && out_ready)
                    sb.compare_result(linear_out, angular_out, zone_flag);
            end
        end
    end

    // watchdog
    initial
    begin
        #2_000_000;
        $display("timeout: run did not complete");
        $display("obstacle_zone_speed_limiter_tb: done, errors");
        $finish;
    end

endmodule

/* obstacle_zone_speed_limiter.f */
hw/rtl/ozsl_pkg.sv
hw/rtl/ozsl_scan.sv
hw/rtl/ozsl_limit.sv
hw/rtl/obstacle_zone_speed_limiter.sv
dv/obstacle_zone_speed_limiter_tb.sv
